/* design/tlc_pkg.sv */
// Shared types and constants for the two-level cache tag directory.
// Used by tlc_level and two_level_cache_lru_tag_model; no dependencies.
package tlc_pkg;

    localparam int ADDR_W = 32;

    localparam int L1_MAX_SETS_DEF = 256;
    localparam int L1_MAX_WAYS_DEF = 8;
    localparam int L2_MAX_SETS_DEF = 1024;
    localparam int L2_MAX_WAYS_DEF = 16;

    // access status codes
    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_RH   = 3'd1;
    localparam logic [2:0] ST_RM   = 3'd2;
    localparam logic [2:0] ST_WH   = 3'd3;
    localparam logic [2:0] ST_WM   = 3'd4;

    localparam logic FUNC_READ = 1'b0;

    typedef enum logic [2:0] {
        REG_L1_OFF  = 3'd0,
        REG_L1_IDX  = 3'd1,
        REG_L1_WAYS = 3'd2,
        REG_L2_OFF  = 3'd3,
        REG_L2_IDX  = 3'd4,
        REG_L2_WAYS = 3'd5
    } reg_idx_t;

    localparam logic [3:0] L1_OFF_RST  = 4'd4;
    localparam logic [3:0] L1_IDX_RST  = 4'd6;
    localparam logic [3:0] L1_WAYS_RST = 4'd4;
    localparam logic [3:0] L2_OFF_RST  = 4'd4;
    localparam logic [3:0] L2_IDX_RST  = 4'd8;
    localparam logic [4:0] L2_WAYS_RST = 5'd8;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] l1_status;
        logic [2:0] l2_status;
    } out_beat_t;

    typedef struct packed {
        logic [3:0] off_bits;
        logic [3:0] idx_bits;
        logic [4:0] ways;
    } lvl_cfg_t;

    typedef struct packed {
        logic rd;     // read the set of the incoming address
        logic upd;    // write back the looked-up set
        logic alloc;  // refill the LRU way on a miss
        logic flush;  // start a clearing pass
    } lvl_ctl_t;

endpackage

/* design/tlc_level.sv */
// One cache level: tag, valid and LRU-age directory in synchronous memories.
// Depends on tlc_pkg.
module tlc_level #(
    parameter int SETS = tlc_pkg::L1_MAX_SETS_DEF,
    parameter int WAYS = tlc_pkg::L1_MAX_WAYS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlc_pkg::lvl_cfg_t  cfg,
    input  tlc_pkg::lvl_ctl_t  ctl,
    input  logic [tlc_pkg::ADDR_W-1:0] address,
    output logic               hit,
    output logic               busy
);

    localparam int TW    = tlc_pkg::ADDR_W;
    localparam int IW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WW    = $clog2(WAYS + 1);
    localparam int IBMAX = $clog2(SETS + 1) - 1;

    logic [WAYS-1:0][TW-1:0] tag_mem [SETS];
    logic [WAYS-1:0]         vld_mem [SETS];
    logic [WAYS-1:0][AW-1:0] age_mem [SETS];

    logic [WAYS-1:0][TW-1:0] tag_rd_reg;
    logic [WAYS-1:0]         vld_rd_reg;
    logic [WAYS-1:0][AW-1:0] age_rd_reg;
    logic [TW-1:0]           addr_reg;

    logic          busy_reg, busy_next;
    logic [IW-1:0] row_reg, row_next;

    logic [WW-1:0] w;
    logic [AW-1:0] wm1;
    logic [3:0]    ib;
    logic [TW-1:0] in_sh, lk_sh, lk_tag, idx_mask;
    logic [IW-1:0] rd_idx, lk_idx, meta_idx;

    logic [WAYS-1:0][TW-1:0] tag_new;
    logic [WAYS-1:0]         vld_new, vld_wr;
    logic [WAYS-1:0][AW-1:0] age_new, age_init, age_wr;
    logic [AW-1:0]           hit_way, victim, hit_age;

    always_comb
    begin
        if (cfg.ways == 5'd0)
            w = WW'(1);
        else if (32'(cfg.ways) > 32'(WAYS))
            w = WW'(WAYS);
        else
            w = WW'(cfg.ways);
        wm1 = AW'(32'(w) - 32'd1);
        ib  = (32'(cfg.idx_bits) > 32'(IBMAX)) ? 4'(IBMAX) : cfg.idx_bits;
    end

    assign idx_mask = (TW'(1) << ib) - TW'(1);
    assign in_sh    = address >> cfg.off_bits;
    assign lk_sh    = addr_reg >> cfg.off_bits;
    assign rd_idx   = IW'(in_sh & idx_mask);
    assign lk_idx   = IW'(lk_sh & idx_mask);
    assign lk_tag   = lk_sh >> ib;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            if (!hit && j < int'(w) && vld_rd_reg[j] && tag_rd_reg[j] == lk_tag)
            begin
                hit     = 1'b1;
                hit_way = AW'(j);
            end
        end
    end

    always_comb
    begin
        hit_age = age_rd_reg[hit_way];
        victim  = '0;
        tag_new = tag_rd_reg;
        vld_new = vld_rd_reg;
        age_new = age_rd_reg;
        if (hit)
        begin
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < int'(w) && age_rd_reg[j] < hit_age)
                    age_new[j] = age_rd_reg[j] + AW'(1);
            end
            age_new[hit_way] = '0;
        end
        else if (ctl.alloc)
        begin
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < int'(w))
                begin
                    if (age_rd_reg[j] == wm1)
                    begin
                        victim     = AW'(j);
                        age_new[j] = '0;
                    end
                    else if (age_rd_reg[j] < wm1)
                        age_new[j] = age_rd_reg[j] + AW'(1);
                end
            end
            tag_new[victim] = lk_tag;
            vld_new[victim] = 1'b1;
        end
    end

    always_comb
    begin
        for (int j = 0; j < WAYS; j++)
            age_init[j] = (j < int'(w)) ? AW'(int'(w) - 1 - j) : '0;
    end

    assign meta_idx = busy_reg ? row_reg : lk_idx;
    assign vld_wr   = busy_reg ? '0 : vld_new;
    assign age_wr   = busy_reg ? age_init : age_new;

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            tag_rd_reg <= tag_mem[rd_idx];
            vld_rd_reg <= vld_mem[rd_idx];
            age_rd_reg <= age_mem[rd_idx];
            addr_reg   <= address;
        end
        if (ctl.upd)
            tag_mem[lk_idx] <= tag_new;
        if (ctl.upd || busy_reg)
        begin
            vld_mem[meta_idx] <= vld_wr;
            age_mem[meta_idx] <= age_wr;
        end
    end

    // clearing pass: one set a cycle
    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (ctl.flush)
        begin
            busy_next = 1'b1;
            row_next  = '0;
        end
        else if (busy_reg)
        begin
            if (row_reg == IW'(SETS - 1))
                busy_next = 1'b0;
            else
                row_next = row_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    assign busy = busy_reg;

endmodule

/* design/two_level_cache_lru_tag_model.sv */
// Two-level set-associative cache tag directory with LRU ages.
// Depends on tlc_pkg and tlc_level.
// The set is read into registers at the edge that takes the input beat; lookup,
// write-back and the registered result beat follow once the output is not stalled.
// A new beat is taken only after the last one's lookup is done; a stalled result
// beat holds the lookup. Reset clears both levels.
// A register write clears only its level.
module two_level_cache_lru_tag_model #(
    parameter int L1_MAX_SETS = tlc_pkg::L1_MAX_SETS_DEF,
    parameter int L1_MAX_WAYS = tlc_pkg::L1_MAX_WAYS_DEF,
    parameter int L2_MAX_SETS = tlc_pkg::L2_MAX_SETS_DEF,
    parameter int L2_MAX_WAYS = tlc_pkg::L2_MAX_WAYS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tlc_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tlc_pkg::out_beat_t   out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] l1_off_reg, l1_idx_reg, l1_ways_reg, l2_off_reg, l2_idx_reg;
    logic [4:0] l2_ways_reg;
    logic       func_reg;
    logic       out_valid_reg, out_valid_next;
    tlc_pkg::out_beat_t out_data_reg, out_data_next;

    tlc_pkg::reg_idx_t  widx;
    tlc_pkg::lvl_cfg_t  l1_cfg, l2_cfg;
    tlc_pkg::lvl_ctl_t  l1_ctl, l2_ctl;
    logic l1_hit, l2_hit, l1_busy, l2_busy;
    logic wr, take, go, is_read;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = tlc_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        case (widx)
            tlc_pkg::REG_L1_OFF:  prdata = 32'(l1_off_reg);
            tlc_pkg::REG_L1_IDX:  prdata = 32'(l1_idx_reg);
            tlc_pkg::REG_L1_WAYS: prdata = 32'(l1_ways_reg);
            tlc_pkg::REG_L2_OFF:  prdata = 32'(l2_off_reg);
            tlc_pkg::REG_L2_IDX:  prdata = 32'(l2_idx_reg);
            tlc_pkg::REG_L2_WAYS: prdata = 32'(l2_ways_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_off_reg  <= tlc_pkg::L1_OFF_RST;
            l1_idx_reg  <= tlc_pkg::L1_IDX_RST;
            l1_ways_reg <= tlc_pkg::L1_WAYS_RST;
            l2_off_reg  <= tlc_pkg::L2_OFF_RST;
            l2_idx_reg  <= tlc_pkg::L2_IDX_RST;
            l2_ways_reg <= tlc_pkg::L2_WAYS_RST;
        end
        else if (wr)
        begin
            case (widx)
                tlc_pkg::REG_L1_OFF:  l1_off_reg  <= pwdata[3:0];
                tlc_pkg::REG_L1_IDX:  l1_idx_reg  <= pwdata[3:0];
                tlc_pkg::REG_L1_WAYS: l1_ways_reg <= pwdata[3:0];
                tlc_pkg::REG_L2_OFF:  l2_off_reg  <= pwdata[3:0];
                tlc_pkg::REG_L2_IDX:  l2_idx_reg  <= pwdata[3:0];
                tlc_pkg::REG_L2_WAYS: l2_ways_reg <= pwdata[4:0];
                default:              ;
            endcase
        end
    end

    assign l1_cfg = '{off_bits: l1_off_reg, idx_bits: l1_idx_reg, ways: {1'b0, l1_ways_reg}};
    assign l2_cfg = '{off_bits: l2_off_reg, idx_bits: l2_idx_reg, ways: l2_ways_reg};

    // no beat is taken in the cycle of a register write
    assign in_stall = (state_reg != S_IDLE) || wr;
    assign take     = in_valid && !in_stall;
    assign go       = (state_reg == S_LOOK) && (!out_valid_reg || !out_stall);
    assign is_read  = (func_reg == tlc_pkg::FUNC_READ);

    always_comb
    begin
        l1_ctl.rd    = take;
        l1_ctl.upd   = go;
        l1_ctl.alloc = is_read;
        l1_ctl.flush = wr && (widx == tlc_pkg::REG_L1_OFF || widx == tlc_pkg::REG_L1_IDX
                              || widx == tlc_pkg::REG_L1_WAYS);
        l2_ctl.rd    = take;
        // L2 is only written back on a write or on an L1 read miss
        l2_ctl.upd   = go && (!is_read || !l1_hit);
        l2_ctl.alloc = is_read;
        l2_ctl.flush = wr && (widx == tlc_pkg::REG_L2_OFF || widx == tlc_pkg::REG_L2_IDX
                              || widx == tlc_pkg::REG_L2_WAYS);
    end

    tlc_level #(
        .SETS (L1_MAX_SETS),
        .WAYS (L1_MAX_WAYS)
    ) u_l1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (l1_cfg),
        .ctl     (l1_ctl),
        .address (in_data.address),
        .hit     (l1_hit),
        .busy    (l1_busy)
    );

    tlc_level #(
        .SETS (L2_MAX_SETS),
        .WAYS (L2_MAX_WAYS)
    ) u_l2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (l2_cfg),
        .ctl     (l2_ctl),
        .address (in_data.address),
        .hit     (l2_hit),
        .busy    (l2_busy)
    );

    always_comb
    begin
        out_data_next = out_data_reg;
        if (is_read)
        begin
            out_data_next.l1_status = l1_hit ? tlc_pkg::ST_RH : tlc_pkg::ST_RM;
            out_data_next.l2_status = l1_hit ? tlc_pkg::ST_NONE
                                    : (l2_hit ? tlc_pkg::ST_RH : tlc_pkg::ST_RM);
        end
        else
        begin
            out_data_next.l1_status = (l1_hit && l2_hit) ? tlc_pkg::ST_WH : tlc_pkg::ST_WM;
            out_data_next.l2_status = l2_hit ? tlc_pkg::ST_WH : tlc_pkg::ST_WM;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (go)
            out_valid_next = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                if (!l1_busy && !l2_busy)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (l1_ctl.flush || l2_ctl.flush)
                    state_next = S_CLEAR;
                else if (take)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (go)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
        if (state_reg == S_CLEAR && (l1_ctl.flush || l2_ctl.flush))
            state_next = S_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            func_reg <= in_data.func;
        if (go)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/two_level_cache_lru_tag_model_test.sv */
// Self-checking testbench for the two-level LRU cache tag directory.
// Depends on tlc_pkg and the two_level_cache_lru_tag_model RTL; holds its own directory model.
`timescale 1ns / 100ps

module two_level_cache_lru_tag_model_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int SET_SLOTS = 16384;
    localparam int HOLD_LEN = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    tlc_pkg::in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    tlc_pkg::out_beat_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    two_level_cache_lru_tag_model DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // directory copy, one row per level
    logic [31:0] dir_tag [2][SET_SLOTS];
    bit dir_valid [2][SET_SLOTS];
    int dir_age [2][SET_SLOTS];
    int lvl_off [2];
    int lvl_idx [2];
    int lvl_ways [2];
    int lvl_max_sets [2] = '{tlc_pkg::L1_MAX_SETS_DEF, tlc_pkg::L2_MAX_SETS_DEF};
    int lvl_max_ways [2] = '{tlc_pkg::L1_MAX_WAYS_DEF, tlc_pkg::L2_MAX_WAYS_DEF};
    int lvl_max_idx [2] = '{8, 10};

    tlc_pkg::out_beat_t status_queue [$];
    int fail_count = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    int hold_req = 0;
    int hold_ack = 0;
    bit idle_on = 1'b1;
    logic [31:0] hot_addr [16];

    function automatic int ways_in_use(int l);
        if (lvl_ways[l] == 0) return 1;
        if (lvl_ways[l] > lvl_max_ways[l]) return lvl_max_ways[l];
        return lvl_ways[l];
    endfunction

    task automatic flush_level(int l);
        int w;
        w = ways_in_use(l);
        for (int s = 0; s < lvl_max_sets[l]; s++)
            for (int j = 0; j < lvl_max_ways[l]; j++)
            begin
                dir_valid[l][s*lvl_max_ways[l] + j] = 1'b0;
                dir_age[l][s*lvl_max_ways[l] + j] = (j < w) ? w - 1 - j : 0;
            end
    endtask

    // lookup with LRU refresh on hit, refill of the oldest way on a miss if alloc
    task automatic lookup_level(int l, logic [31:0] addr, bit alloc, output bit hit);
        int w, ib, b, base, a, victim;
        logic [63:0] wide, set_no, tg;
        w = ways_in_use(l);
        ib = (lvl_idx[l] < lvl_max_idx[l]) ? lvl_idx[l] : lvl_max_idx[l];
        b = lvl_off[l];
        wide = {32'd0, addr};
        set_no = (wide >> b) & ((64'd1 << ib) - 64'd1);
        tg = wide >> (b + ib);
        base = int'(set_no) * lvl_max_ways[l];
        hit = 1'b0;
        for (int j = 0; j < w && !hit; j++)
            if (dir_valid[l][base+j] && dir_tag[l][base+j] == tg[31:0])
            begin
                hit = 1'b1;
                a = dir_age[l][base+j];
                for (int k = 0; k < w; k++)
                    if (dir_age[l][base+k] < a) dir_age[l][base+k]++;
                dir_age[l][base+j] = 0;
            end
        if (!hit && alloc)
        begin
            victim = 0;
            for (int k = 0; k < w; k++)
                if (dir_age[l][base+k] == w - 1)
                begin
                    victim = k;
                    dir_age[l][base+k] = 0;
                end
                else if (dir_age[l][base+k] < w - 1)
                    dir_age[l][base+k]++;
            dir_tag[l][base+victim] = tg[31:0];
            dir_valid[l][base+victim] = 1'b1;
        end
    endtask

    task automatic predict_status(tlc_pkg::in_beat_t beat);
        tlc_pkg::out_beat_t res;
        bit h1, h2;
        if (beat.func == tlc_pkg::FUNC_READ)
        begin
            lookup_level(0, beat.address, 1'b1, h1);
            if (h1)
            begin
                res.l1_status = tlc_pkg::ST_RH;
                res.l2_status = tlc_pkg::ST_NONE;
            end
            else
            begin
                lookup_level(1, beat.address, 1'b1, h2);
                res.l1_status = tlc_pkg::ST_RM;
                res.l2_status = h2 ? tlc_pkg::ST_RH : tlc_pkg::ST_RM;
            end
        end
        else
        begin
            lookup_level(0, beat.address, 1'b0, h1);
            lookup_level(1, beat.address, 1'b0, h2);
            res.l1_status = (h1 && h2) ? tlc_pkg::ST_WH : tlc_pkg::ST_WM;
            res.l2_status = h2 ? tlc_pkg::ST_WH : tlc_pkg::ST_WM;
        end
        status_queue.push_back(res);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("Regression FAIL");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_queue.size() == 0)
                report("unexpected beat", int'(out_data), 0);
            else
            begin
                if (out_data.l1_status != status_queue[0].l1_status)
                    report("l1_status", int'(out_data.l1_status),
                           int'(status_queue[0].l1_status));
                if (out_data.l2_status != status_queue[0].l2_status)
                    report("l2_status", int'(out_data.l2_status),
                           int'(status_queue[0].l2_status));
                void'(status_queue.pop_front());
            end
        end
    end

    // receiver stall: long hold-off on request, random otherwise
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LEN - 1;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= idle_on && ($urandom % 100 < 10);
    end

    task automatic send_beat(logic func, logic [31:0] addr);
        tlc_pkg::in_beat_t beat;
        beat.func = func;
        beat.address = addr;
        @(negedge clk);
        while (idle_on && ($urandom % 100 < 10))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (in_stall);
        predict_status(beat);
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_queue.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(tlc_pkg::reg_idx_t r, logic [31:0] value);
        int l;
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * int'(r));
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        l = int'(r) / 3;
        case (r)
            tlc_pkg::REG_L1_OFF, tlc_pkg::REG_L2_OFF: lvl_off[l] = value & 15;
            tlc_pkg::REG_L1_IDX, tlc_pkg::REG_L2_IDX: lvl_idx[l] = value & 15;
            default: lvl_ways[l] = value & ((r == tlc_pkg::REG_L2_WAYS) ? 31 : 15);
        endcase
        flush_level(l);
    endtask

    task automatic set_geometry(int o1, int i1, int w1, int o2, int i2, int w2);
        write_reg(tlc_pkg::REG_L1_OFF, o1);
        write_reg(tlc_pkg::REG_L1_IDX, i1);
        write_reg(tlc_pkg::REG_L1_WAYS, w1);
        write_reg(tlc_pkg::REG_L2_OFF, o2);
        write_reg(tlc_pkg::REG_L2_IDX, i2);
        write_reg(tlc_pkg::REG_L2_WAYS, w2);
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom % 100;
        if (r < 55) return 32'($urandom_range(0, 511)) << 4;
        if (r < 85) return hot_addr[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    task automatic random_beats(int count);
        for (int n = 0; n < count; n++)
            send_beat(($urandom % 100 < 30) ? ~tlc_pkg::FUNC_READ : tlc_pkg::FUNC_READ,
                      pick_addr());
    endtask

    task automatic test_directed;
        send_beat(tlc_pkg::FUNC_READ, 32'h0000_0000);     // cold miss both levels
        send_beat(tlc_pkg::FUNC_READ, 32'h0000_0008);     // same block: L1 hit
        send_beat(~tlc_pkg::FUNC_READ, 32'h0000_000c);    // write hit both
        send_beat(~tlc_pkg::FUNC_READ, 32'hffff_ffff);    // write miss, no allocate
        send_beat(tlc_pkg::FUNC_READ, 32'hffff_ffff);
        send_beat(tlc_pkg::FUNC_READ, 32'hffff_fff0);
        send_beat(~tlc_pkg::FUNC_READ, 32'hffff_ffff);
        // fill one L1 set past its ways so L1 evicts but L2 still holds
        for (int k = 0; k < 6; k++)
            send_beat(tlc_pkg::FUNC_READ, 32'(k) << 10);
        send_beat(tlc_pkg::FUNC_READ, 32'h0000_0000);
        send_beat(~tlc_pkg::FUNC_READ, 32'h0000_0400);
        // L2 flush alone: L1 hit with L2 miss on a write counts as a write miss
        write_reg(tlc_pkg::REG_L2_WAYS, 8);
        send_beat(~tlc_pkg::FUNC_READ, 32'h0000_0000);
        send_beat(tlc_pkg::FUNC_READ, 32'h0000_0000);
        send_beat(~tlc_pkg::FUNC_READ, 32'haaaa_5555);
        send_beat(tlc_pkg::FUNC_READ, 32'h5555_aaaa);
    endtask

    task automatic test_geometry_extremes;
        // zero ways, single set, byte blocks
        set_geometry(0, 0, 0, 0, 0, 0);
        random_beats(40);
        // ways beyond the maximum, index bits beyond the maximum, widest offset field
        set_geometry(15, 15, 15, 15, 15, 31);
        random_beats(40);
        set_geometry(12, 8, 8, 12, 10, 16);
        random_beats(40);
        set_geometry(0, 1, 1, 2, 1, 1);
        random_beats(40);
    endtask

    task automatic test_random;
        set_geometry(4, 3, 2, 5, 4, 4);
        random_beats(250);
        idle_on = 1'b0;
        random_beats(200);
        idle_on = 1'b1;
        set_geometry(6, 2, 8, 4, 3, 16);
        random_beats(250);
        set_geometry(2, 5, 3, 3, 6, 5);
        random_beats(300);
    endtask

    task automatic test_backpressure;
        drain();
        hold_req++;
        random_beats(60);
    endtask

    initial
    begin
        foreach (hot_addr[k]) hot_addr[k] = $urandom;
        lvl_off = '{4, 4};
        lvl_idx = '{6, 8};
        lvl_ways = '{4, 8};
        flush_level(0);
        flush_level(1);
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_geometry_extremes();
        test_random();
        test_backpressure();
        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
